FILE: hdl/bstpu_pkg.sv
// Package for the spanning-tree port update block.
// Field widths, register map codes and the configuration struct.
// No dependencies.
`timescale 1ns / 1ps

package bstpu_pkg;

   localparam int DEFAULT_NUM_PORTS = 16;

   localparam int ID_W       = 16;
   localparam int DIST_W     = 8;
   localparam int PORT_W     = 4;
   localparam int USED_W     = 5;
   localparam int BPORT_W    = 5;
   localparam int MASK_W     = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [BPORT_W-1:0] NO_PORT       = 5'd16;
   localparam logic [USED_W-1:0]  PORTS_USED_RST = 5'd16;
   localparam logic [DIST_W-1:0]  DIST_MAX      = 8'hFF;

   typedef enum logic {
      REG_BRIDGE_ID  = 1'b0,
      REG_PORTS_USED = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [ID_W-1:0]   bridge_id;
      logic [USED_W-1:0] ports_used;
      logic              init;
      logic [ID_W-1:0]   init_id;
   } cfg_type;

endpackage

FILE: hdl/bstpu_csr.sv
// Configuration registers of the spanning-tree port update block.
// APB-style write/read port; drives the configuration struct.
// Depends on bstpu_pkg.
`timescale 1ns / 1ps

module bstpu_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bstpu_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bstpu_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bstpu_pkg::CSR_DATA_W-1:0] prdata,
   output logic                             pready,
   output bstpu_pkg::cfg_type               cfg
);
   import bstpu_pkg::*;

   logic [ID_W-1:0]   bridge_id_ff;
   logic [ID_W-1:0]   bridge_id_in;
   logic [USED_W-1:0] ports_used_ff;
   logic [USED_W-1:0] ports_used_in;
   logic              wr_en;
   reg_index_type     wr_index;

   assign pready   = 1'b1;
   assign wr_en    = psel & penable & pwrite & pready;
   assign wr_index = reg_index_type'(paddr[2]);

   always_comb begin
      bridge_id_in  = bridge_id_ff;
      ports_used_in = ports_used_ff;
      if (wr_en) begin
         case (wr_index)
            REG_BRIDGE_ID:  bridge_id_in  = pwdata[ID_W-1:0];
            REG_PORTS_USED: ports_used_in = pwdata[USED_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bridge_id_ff  <= '0;
         ports_used_ff <= PORTS_USED_RST;
      end else begin
         bridge_id_ff  <= bridge_id_in;
         ports_used_ff <= ports_used_in;
      end
   end

   always_comb begin
      case (reg_index_type'(paddr[2]))
         REG_BRIDGE_ID:  prdata = CSR_DATA_W'(bridge_id_ff);
         REG_PORTS_USED: prdata = CSR_DATA_W'(ports_used_ff);
         default:        prdata = '0;
      endcase
   end

   assign cfg.bridge_id  = bridge_id_ff;
   assign cfg.ports_used = ports_used_ff;
   assign cfg.init       = wr_en && (wr_index == REG_BRIDGE_ID);
   assign cfg.init_id    = pwdata[ID_W-1:0];

endmodule

FILE: hdl/bridge_spanning_tree_port_update.sv
// Spanning-tree port update for one bridge: top level.
// Holds the input register, the per-port best tables, node best and result register.
// Depends on bstpu_pkg and bstpu_csr.
`timescale 1ns / 1ps

// Each transaction on req_ carries one configuration message received on one port
// and yields exactly one rsp_ transaction with the open-port mask, the accepted
// flag and the node best configuration after that message. In the input register a
// message is compared against the register-held port tables and the node best;
// the tables and the result register are written when it advances, so one
// message per cycle is sustained while rsp_ready is high; the message passes the
// input register and then the result register before rsp_valid. rsp_ready low
// holds the result and stalls the input register only once the result register
// is occupied. Writing bridge_id reinitialises all tables in the same cycle;
// ports_used counts above NUM_PORTS act as NUM_PORTS.
module bridge_spanning_tree_port_update #(
   parameter int NUM_PORTS = bstpu_pkg::DEFAULT_NUM_PORTS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bstpu_pkg::PORT_W-1:0]     req_port_index,
   input  logic [bstpu_pkg::ID_W-1:0]       req_msg_root,
   input  logic [bstpu_pkg::DIST_W-1:0]     req_msg_distance,
   input  logic [bstpu_pkg::ID_W-1:0]       req_msg_sender,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bstpu_pkg::MASK_W-1:0]     rsp_open_mask,
   output logic                             rsp_accepted,
   output logic [bstpu_pkg::ID_W-1:0]       rsp_best_root,
   output logic [bstpu_pkg::DIST_W-1:0]     rsp_best_distance,
   output logic [bstpu_pkg::ID_W-1:0]       rsp_best_sender,
   output logic [bstpu_pkg::BPORT_W-1:0]    rsp_root_port,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bstpu_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bstpu_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bstpu_pkg::CSR_DATA_W-1:0] prdata,
   output logic                             pready
);
   import bstpu_pkg::*;

   localparam int OUT_BITS = (NUM_PORTS < MASK_W) ? NUM_PORTS : MASK_W;

   function automatic logic triple_less(
      input logic [ID_W-1:0] r1, input logic [DIST_W-1:0] d1, input logic [ID_W-1:0] s1,
      input logic [ID_W-1:0] r2, input logic [DIST_W-1:0] d2, input logic [ID_W-1:0] s2
   );
      logic lt;
      if (r1 != r2)
         lt = r1 < r2;
      else if (d1 != d2)
         lt = d1 < d2;
      else
         lt = s1 < s2;
      return lt;
   endfunction

   cfg_type cfg;

   bstpu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // input register
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [PORT_W-1:0] in_port_ff;
   logic [ID_W-1:0]   in_root_ff;
   logic [DIST_W-1:0] in_dist_ff;
   logic [ID_W-1:0]   in_sender_ff;

   // port tables and node best
   logic [ID_W-1:0]      root_ff   [NUM_PORTS];
   logic [ID_W-1:0]      root_in   [NUM_PORTS];
   logic [DIST_W-1:0]    dist_ff   [NUM_PORTS];
   logic [DIST_W-1:0]    dist_in   [NUM_PORTS];
   logic [ID_W-1:0]      sender_ff [NUM_PORTS];
   logic [ID_W-1:0]      sender_in [NUM_PORTS];
   logic [ID_W-1:0]      node_root_ff,   node_root_in;
   logic [DIST_W-1:0]    node_dist_ff,   node_dist_in;
   logic [ID_W-1:0]      node_sender_ff, node_sender_in;
   logic [BPORT_W-1:0]   best_port_ff,   best_port_in;
   logic [NUM_PORTS-1:0] port_open_ff,   port_open_in;

   // result register
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [MASK_W-1:0] out_mask_ff;
   logic              out_acc_ff;
   logic [ID_W-1:0]   out_root_ff;
   logic [DIST_W-1:0] out_dist_ff;
   logic [ID_W-1:0]   out_sender_ff;
   logic [BPORT_W-1:0] out_port_ff;

   logic                 advance;
   logic                 load;
   logic [NUM_PORTS-1:0] hit;
   logic [NUM_PORTS-1:0] in_use;
   logic [ID_W-1:0]      sel_root;
   logic [DIST_W-1:0]    sel_dist;
   logic [ID_W-1:0]      sel_sender;
   logic                 port_ok;
   logic                 msg_acc;
   logic                 node_upd;
   logic [DIST_W-1:0]    dist_sat;
   logic [BPORT_W-1:0]   best_port_new;
   logic [NUM_PORTS-1:0] mask_new;
   logic [ID_W-1:0]      sender_new;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign load        = req_valid && req_ready;
   assign in_valid_in = load || (in_valid_ff && !advance);

   always_comb begin
      sel_root   = '0;
      sel_dist   = '0;
      sel_sender = '0;
      for (int p = 0; p < NUM_PORTS; p++) begin
         hit[p]    = (32'(p) == 32'(in_port_ff));
         in_use[p] = (32'(p) < 32'(cfg.ports_used));
         if (hit[p]) begin
            sel_root   = sel_root | root_ff[p];
            sel_dist   = sel_dist | dist_ff[p];
            sel_sender = sel_sender | sender_ff[p];
         end
      end
      port_ok  = |(hit & in_use & port_open_ff);
      msg_acc  = port_ok && triple_less(in_root_ff, in_dist_ff, in_sender_ff,
                                        sel_root, sel_dist, sel_sender);
      dist_sat = (in_dist_ff == DIST_MAX) ? DIST_MAX : in_dist_ff + DIST_W'(1);
      node_upd = msg_acc && triple_less(in_root_ff, dist_sat, in_sender_ff,
                                        node_root_ff, node_dist_ff, node_sender_ff);
      best_port_new = node_upd ? BPORT_W'(in_port_ff) : best_port_ff;

      for (int p = 0; p < NUM_PORTS; p++) begin
         sender_new  = (msg_acc && hit[p]) ? in_sender_ff : sender_ff[p];
         mask_new[p] = in_use[p] &&
                       ((sender_new == cfg.bridge_id) || (32'(p) == 32'(best_port_new)));
      end

      for (int p = 0; p < NUM_PORTS; p++) begin
         root_in[p]   = root_ff[p];
         dist_in[p]   = dist_ff[p];
         sender_in[p] = sender_ff[p];
      end
      node_root_in   = node_root_ff;
      node_dist_in   = node_dist_ff;
      node_sender_in = node_sender_ff;
      best_port_in   = best_port_ff;
      port_open_in   = port_open_ff;

      if (cfg.init) begin
         for (int p = 0; p < NUM_PORTS; p++) begin
            root_in[p]   = cfg.init_id;
            dist_in[p]   = '0;
            sender_in[p] = cfg.init_id;
         end
         node_root_in   = cfg.init_id;
         node_dist_in   = '0;
         node_sender_in = cfg.init_id;
         best_port_in   = NO_PORT;
         port_open_in   = '1;
      end else if (advance) begin
         for (int p = 0; p < NUM_PORTS; p++) begin
            if (msg_acc && hit[p]) begin
               root_in[p]   = in_root_ff;
               dist_in[p]   = dist_sat;
               sender_in[p] = in_sender_ff;
            end
            if (node_upd && in_use[p])
               root_in[p] = in_root_ff;
         end
         if (node_upd) begin
            node_root_in   = in_root_ff;
            node_dist_in   = dist_sat;
            node_sender_in = in_sender_ff;
         end
         best_port_in = best_port_new;
         port_open_in = mask_new;
      end
   end

   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_port_ff   <= req_port_index;
         in_root_ff   <= req_msg_root;
         in_dist_ff   <= req_msg_distance;
         in_sender_ff <= req_msg_sender;
      end
      if (advance) begin
         out_mask_ff   <= MASK_W'(mask_new[OUT_BITS-1:0]);
         out_acc_ff    <= msg_acc;
         out_root_ff   <= node_root_in;
         out_dist_ff   <= node_dist_in;
         out_sender_ff <= node_sender_in;
         out_port_ff   <= best_port_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PORTS; p++) begin
            root_ff[p]   <= '0;
            dist_ff[p]   <= '0;
            sender_ff[p] <= '0;
         end
         node_root_ff   <= '0;
         node_dist_ff   <= '0;
         node_sender_ff <= '0;
         best_port_ff   <= NO_PORT;
         port_open_ff   <= '1;
      end else begin
         for (int p = 0; p < NUM_PORTS; p++) begin
            root_ff[p]   <= root_in[p];
            dist_ff[p]   <= dist_in[p];
            sender_ff[p] <= sender_in[p];
         end
         node_root_ff   <= node_root_in;
         node_dist_ff   <= node_dist_in;
         node_sender_ff <= node_sender_in;
         best_port_ff   <= best_port_in;
         port_open_ff   <= port_open_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_open_mask     = out_mask_ff;
   assign rsp_accepted      = out_acc_ff;
   assign rsp_best_root     = out_root_ff;
   assign rsp_best_distance = out_dist_ff;
   assign rsp_best_sender   = out_sender_ff;
   assign rsp_root_port     = out_port_ff;

endmodule

FILE: test/tb_bridge_spanning_tree_port_update.sv
// Testbench for bridge_spanning_tree_port_update: directed and random messages,
// each response checked against an in-bench model of the per-port and node best tables.
// Depends on bstpu_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_bridge_spanning_tree_port_update;
   import bstpu_pkg::*;

   localparam int NPORTS = DEFAULT_NUM_PORTS;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_ITEMS = 130;
   localparam int RANDOM_PHASES = 8;

   typedef struct packed {
      logic [MASK_W-1:0]  open_mask;
      logic               accepted;
      logic [ID_W-1:0]    best_root;
      logic [DIST_W-1:0]  best_distance;
      logic [ID_W-1:0]    best_sender;
      logic [BPORT_W-1:0] root_port;
   } port_update_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [PORT_W-1:0]     req_port_index = '0;
   logic [ID_W-1:0]       req_msg_root = '0;
   logic [DIST_W-1:0]     req_msg_distance = '0;
   logic [ID_W-1:0]       req_msg_sender = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [MASK_W-1:0]     rsp_open_mask;
   logic                  rsp_accepted;
   logic [ID_W-1:0]       rsp_best_root;
   logic [DIST_W-1:0]     rsp_best_distance;
   logic [ID_W-1:0]       rsp_best_sender;
   logic [BPORT_W-1:0]    rsp_root_port;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // model state
   logic [ID_W-1:0]    cfg_bridge_id;
   logic [USED_W-1:0]  cfg_ports_used;
   logic [ID_W-1:0]    tbl_root [NPORTS];
   logic [DIST_W-1:0]  tbl_dist [NPORTS];
   logic [ID_W-1:0]    tbl_sender [NPORTS];
   logic [ID_W-1:0]    node_root;
   logic [DIST_W-1:0]  node_dist;
   logic [ID_W-1:0]    node_sender;
   logic [BPORT_W-1:0] node_port;
   logic [MASK_W-1:0]  open_ports;

   port_update_type pending_results [$];
   int failures = 0;
   int quiet_cycles = 0;
   int burst_left = 0;
   bit valid_held = 0;
   int rx_mode = 0;
   int rx_mode_left = 0;
   int rx_stall_left = 0;

   bridge_spanning_tree_port_update DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_port_index(req_port_index), .req_msg_root(req_msg_root),
      .req_msg_distance(req_msg_distance), .req_msg_sender(req_msg_sender),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_open_mask(rsp_open_mask), .rsp_accepted(rsp_accepted),
      .rsp_best_root(rsp_best_root), .rsp_best_distance(rsp_best_distance),
      .rsp_best_sender(rsp_best_sender), .rsp_root_port(rsp_root_port),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #6 clock = ~clock;

   function automatic void init_best_tables();
      int p;
      for (p = 0; p < NPORTS; p++) begin
         tbl_root[p] = cfg_bridge_id;
         tbl_dist[p] = '0;
         tbl_sender[p] = cfg_bridge_id;
      end
      node_root = cfg_bridge_id;
      node_dist = '0;
      node_sender = cfg_bridge_id;
      node_port = NO_PORT;
      open_ports = '1;
   endfunction

   function automatic port_update_type update_best_tables(input logic [PORT_W-1:0] port,
                                                          input logic [ID_W-1:0] root,
                                                          input logic [DIST_W-1:0] distance,
                                                          input logic [ID_W-1:0] sender);
      int n;
      int p;
      logic [DIST_W-1:0] hop_dist;
      port_update_type r;
      n = (cfg_ports_used > NPORTS) ? NPORTS : cfg_ports_used;
      r.accepted = 1'b0;
      if (port < n && open_ports[port]) begin
         if ({root, distance, sender} < {tbl_root[port], tbl_dist[port], tbl_sender[port]}) begin
            r.accepted = 1'b1;
            hop_dist = (distance == DIST_MAX) ? DIST_MAX : distance + DIST_W'(1);
            tbl_root[port] = root;
            tbl_dist[port] = hop_dist;
            tbl_sender[port] = sender;
            if ({root, hop_dist, sender} < {node_root, node_dist, node_sender}) begin
               node_root = root;
               node_dist = hop_dist;
               node_sender = sender;
               node_port = BPORT_W'(port);
               for (p = 0; p < n; p++)
                  tbl_root[p] = root;
            end
         end
      end
      open_ports = '0;
      for (p = 0; p < n; p++)
         if (tbl_sender[p] == cfg_bridge_id || p == node_port)
            open_ports[p] = 1'b1;
      r.open_mask = open_ports;
      r.best_root = node_root;
      r.best_distance = node_dist;
      r.best_sender = node_sender;
      r.root_port = node_port;
      return r;
   endfunction

   task automatic send_message(input logic [PORT_W-1:0] port, input logic [ID_W-1:0] root,
                               input logic [DIST_W-1:0] distance,
                               input logic [ID_W-1:0] sender);
      int gap;
      req_valid <= 1'b1;
      valid_held = 1;
      req_port_index <= port;
      req_msg_root <= root;
      req_msg_distance <= distance;
      req_msg_sender <= sender;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(update_best_tables(port, root, distance, sender));
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            valid_held = 0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_idle();
      if (valid_held) begin
         req_valid <= 1'b0;
         valid_held = 0;
      end
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      wait_idle();
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == REG_BRIDGE_ID) begin
         cfg_bridge_id = value[ID_W-1:0];
         init_best_tables();
      end else begin
         cfg_ports_used = value[USED_W-1:0];
      end
   endtask

   // bridge id 0 at reset: nothing can beat (0, 0, 0)
   task automatic test_reset_defaults();
      send_message(4'd15, 16'hFFFF, 8'hFF, 16'hFFFF);
      send_message(4'd0, 16'h0000, 8'h00, 16'h0000);
      send_message(4'd7, 16'h0000, 8'h00, 16'h0001);
   endtask

   task automatic test_best_port_and_closing();
      csr_write(REG_BRIDGE_ID, 32'h0000_FFFF);
      csr_write(REG_PORTS_USED, 32'd16);
      send_message(4'd3, 16'h1000, 8'hFF, 16'h2000);
      send_message(4'd3, 16'h1000, 8'hFF, 16'h2000);
      send_message(4'd5, 16'h0800, 8'd3, 16'h1234);
      send_message(4'd3, 16'h0001, 8'd0, 16'h0000);
      send_message(4'd6, 16'h0800, 8'd0, 16'h0001);
      send_message(4'd6, 16'h0800, 8'd0, 16'h0000);
      send_message(4'd9, 16'h07FF, 8'd254, 16'hFFFF);
      send_message(4'd15, 16'h0000, 8'd0, 16'h0000);
      send_message(4'd14, 16'hFFFF, 8'd0, 16'hFFFF);
   endtask

   task automatic test_ports_in_use();
      csr_write(REG_PORTS_USED, 32'd1);
      send_message(4'd2, 16'h0000, 8'd0, 16'h0000);
      send_message(4'd0, 16'h0000, 8'd0, 16'h0000);
      csr_write(REG_PORTS_USED, 32'd0);
      send_message(4'd0, 16'h0000, 8'd0, 16'h0000);
      csr_write(REG_PORTS_USED, 32'd31);
      send_message(4'd15, 16'h0000, 8'd0, 16'h0000);
      send_message(4'd4, 16'h0000, 8'd0, 16'h0000);
      csr_write(REG_BRIDGE_ID, 32'h0000_0000);
      send_message(4'd1, 16'hFFFF, 8'hFF, 16'hFFFF);
   endtask

   task automatic test_random_traffic();
      int ph;
      int i;
      int k;
      int start;
      int n;
      int p;
      int sel;
      logic [PORT_W-1:0] port;
      logic [ID_W-1:0] root;
      logic [DIST_W-1:0] distance;
      logic [ID_W-1:0] sender;
      bit found;
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin
               csr_write(REG_BRIDGE_ID, 32'h0000_FFFF);
               csr_write(REG_PORTS_USED, 32'd16);
            end
            1: begin
               csr_write(REG_BRIDGE_ID, $urandom_range(0, 16'hFFFF));
               csr_write(REG_PORTS_USED, 32'd31);
            end
            2: begin
               csr_write(REG_BRIDGE_ID, $urandom_range(16'h4000, 16'hFFFF));
               csr_write(REG_PORTS_USED, 32'd1);
            end
            3: begin
               csr_write(REG_BRIDGE_ID, $urandom_range(16'h4000, 16'hFFFF));
               csr_write(REG_PORTS_USED, 32'd2);
            end
            4: begin
               csr_write(REG_BRIDGE_ID, 32'h0000_8000);
               csr_write(REG_PORTS_USED, $urandom_range(1, 16));
            end
            5: begin
               csr_write(REG_BRIDGE_ID, $urandom_range(0, 16'hFFFF));
               csr_write(REG_PORTS_USED, 32'd17);
            end
            6: begin
               csr_write(REG_BRIDGE_ID, $urandom_range(16'h1000, 16'hFFFF));
               csr_write(REG_PORTS_USED, $urandom_range(1, 16));
            end
            default: begin
               csr_write(REG_BRIDGE_ID, 32'h0000_0001);
               csr_write(REG_PORTS_USED, 32'd16);
            end
         endcase
         for (i = 0; i < PHASE_ITEMS; i++) begin
            // ports_used change without reinit leaves the old mask in place
            if (i == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 1)
               csr_write(REG_PORTS_USED, ($urandom_range(0, 4) == 0) ? 31 : $urandom_range(1, 16));
            n = (cfg_ports_used > NPORTS) ? NPORTS : cfg_ports_used;
            found = 0;
            start = $urandom_range(0, NPORTS - 1);
            port = '0;
            for (k = 0; k < NPORTS; k++) begin
               p = (start + k) % NPORTS;
               if (!found && p < n && open_ports[p]) begin
                  port = PORT_W'(p);
                  found = 1;
               end
            end
            sel = $urandom_range(0, 9);
            if (!found || sel < 2) begin
               port = PORT_W'($urandom_range(0, NPORTS - 1));
               root = ID_W'($urandom_range(0, 16'hFFFF));
               distance = DIST_W'($urandom_range(0, 255));
               sender = ID_W'($urandom_range(0, 16'hFFFF));
            end else begin
               distance = ($urandom_range(0, 5) == 0) ? DIST_W'($urandom_range(0, 255))
                                                      : DIST_W'($urandom_range(0, 7));
               sender = ($urandom_range(0, 3) == 0) ? cfg_bridge_id
                                                    : ID_W'($urandom_range(0, 16'hFFFF));
               case ($urandom_range(0, 3))
                  0: begin
                     k = $urandom_range(0, 3);
                     root = (node_root > k) ? ID_W'(node_root - k) : '0;
                  end
                  1: begin
                     root = tbl_root[port];
                     distance = DIST_W'($urandom_range(0, tbl_dist[port]));
                  end
                  2: root = node_root;
                  default: root = ID_W'($urandom_range(0, node_root));
               endcase
            end
            send_message(port, root, distance, sender);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(50, 300);
         end else begin
            rx_mode_left--;
         end
         case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: begin
               if (rx_stall_left > 0) begin
                  rx_stall_left--;
                  rsp_ready <= 1'b0;
               end else begin
                  rsp_ready <= 1'b1;
                  if ($urandom_range(0, 15) == 0)
                     rx_stall_left = $urandom_range(1, 60);
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      port_update_type got;
      port_update_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_open_mask, rsp_accepted, rsp_best_root, rsp_best_distance,
                rsp_best_sender, rsp_root_port};
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected rsp transaction: mask=%h acc=%0d best=(%h,%0d,%h) port=%0d",
                        got.open_mask, got.accepted, got.best_root, got.best_distance,
                        got.best_sender, got.root_port);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               failures++;
               if (failures <= 10)
                  $display("rsp mismatch: expected mask=%h acc=%0d best=(%h,%0d,%h) port=%0d, %s",
                           want.open_mask, want.accepted, want.best_root, want.best_distance,
                           want.best_sender, want.root_port,
                           $sformatf("got mask=%h acc=%0d best=(%h,%0d,%h) port=%0d",
                                     got.open_mask, got.accepted, got.best_root,
                                     got.best_distance, got.best_sender, got.root_port));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("bridge_spanning_tree_port_update: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      cfg_bridge_id = '0;
      cfg_ports_used = PORTS_USED_RST;
      init_best_tables();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_best_port_and_closing();
      test_ports_in_use();
      test_random_traffic();
      wait_idle();
      if (failures == 0) begin
         $display("bridge_spanning_tree_port_update: match");
      end else begin
         $display("bridge_spanning_tree_port_update: mismatch");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/bstpu_pkg.sv
hdl/bstpu_csr.sv
hdl/bridge_spanning_tree_port_update.sv
test/tb_bridge_spanning_tree_port_update.sv
